>>> src/mmh_pkg.sv
// shared types and constants for the max-min heap engine
// no dependencies
package mmh_pkg;
  localparam int CAPACITY_DEF = 64;
  localparam int KEY_W = 32;
  localparam int ACT_W = 16;
  localparam int CNT_W = 7;

  typedef enum logic [2:0] {
    OP_PEEK    = 3'd0,
    OP_APPEND  = 3'd1,
    OP_BUILD   = 3'd2,
    OP_REPLACE = 3'd3,
    OP_SETMIN  = 3'd4,
    OP_REMOVE  = 3'd5
  } opcode_t;
endpackage

>>> src/mmh_store.sv
// entry memory of the max-min heap: key and action per slot
// one write port, one read port, registered read data; uses mmh_pkg
module mmh_store #(
  parameter int DEPTH = mmh_pkg::CAPACITY_DEF,
  parameter int AW = $clog2(DEPTH)
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [AW-1:0]            waddr,
  input  logic [mmh_pkg::KEY_W-1:0] wkey,
  input  logic [mmh_pkg::ACT_W-1:0] wact,
  input  logic [AW-1:0]            raddr,
  output logic [mmh_pkg::KEY_W-1:0] rkey,
  output logic [mmh_pkg::ACT_W-1:0] ract
);
  import mmh_pkg::*;

  logic [KEY_W+ACT_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= {wkey, wact};
  end

  always_ff @(posedge clk) begin
    {rkey, ract} <= mem[raddr];
  end
endmodule

>>> src/max_min_heap_engine.sv
// max-min heap engine top level: command decode and push-down sequencer
// uses mmh_pkg and mmh_store
//
// One command at a time: start is taken while busy is low, and the result
// appears on the result ports with done high for one cycle; the receiver
// cannot stall. Entries live in a single-port-read memory, so every entry
// read takes an address step and then a data step. Peek and append run
// three report reads of indices 0, 1 and 2, a result step and the return to
// idle. Set-min adds reads of indices 0, 1, 2 and the last entry and the write.
// A push-down level reads the node and up to six candidates and writes up to
// four entries; replace max and remove min push down level by level from the
// root or the min slot, and build runs one push-down for each of count/2 nodes.
module max_min_heap_engine #(
  parameter int CAPACITY = mmh_pkg::CAPACITY_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [2:0]                opcode,
  input  logic signed [mmh_pkg::KEY_W-1:0] key,
  input  logic [mmh_pkg::ACT_W-1:0] action,
  output logic                      done,
  output logic signed [mmh_pkg::KEY_W-1:0] max_key,
  output logic [mmh_pkg::ACT_W-1:0] max_action,
  output logic signed [mmh_pkg::KEY_W-1:0] min_key,
  output logic [mmh_pkg::ACT_W-1:0] min_act,
  output logic [mmh_pkg::CNT_W-1:0] count,
  output logic                      is_empty,
  output logic                      op_error
);
  import mmh_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int NW = $clog2(CAPACITY + 1);
  localparam int IW = AW + 3;   // wide enough for 4*i+6 comparisons

  typedef enum logic [13:0] {
    S_IDLE  = 14'd1,
    S_MINRD = 14'd2,    // read 0, 1, 2 and last to locate min
    S_MINWT = 14'd4,
    S_OPDO  = 14'd8,    // act on located min
    S_PDSET = 14'd16,   // start a push-down level at node i
    S_CRD   = 14'd32,   // read node i and candidates
    S_CWT   = 14'd64,
    S_SWP   = 14'd128,  // write back i and m
    S_PRD   = 14'd256,  // read parent of m
    S_PWT   = 14'd512,
    S_PSWP  = 14'd1024,
    S_RPT   = 14'd2048, // read 0,1,2 for report
    S_RWT   = 14'd4096,
    S_DONE  = 14'd8192
  } state_t;

  state_t state;
  logic [2:0] op;
  logic signed [KEY_W-1:0] kin;
  logic [ACT_W-1:0] ain;
  logic [NW-1:0] n;        // entry count
  logic [NW-1:0] pn;       // heap size during push-down
  logic [IW-1:0] pi;       // push-down node
  logic          pmax;
  logic [NW-1:0] bnode;    // build node + 1, counts down
  logic          err;
  logic [2:0]    rcnt;
  logic [2:0]    widx;     // write step counter
  logic [IW-1:0] raddr_w;
  logic [IW-1:0] m;
  logic signed [KEY_W-1:0] mkey, ikey, pkey, k1;
  logic [ACT_W-1:0] mact, iact, pact;
  logic [AW-1:0] minix;
  logic signed [KEY_W-1:0] rep_key [3];
  logic [ACT_W-1:0] rep_act [3];

  logic we;
  logic [AW-1:0] waddr, raddr;
  logic signed [KEY_W-1:0] wkey, rkey;
  logic [ACT_W-1:0] wact, ract;

  mmh_store #(.DEPTH(CAPACITY), .AW(AW)) u_store (
    .clk(clk), .we(we), .waddr(waddr), .wkey(wkey), .wact(wact),
    .raddr(raddr), .rkey(rkey), .ract(ract)
  );

  assign busy = (state != S_IDLE);
  assign raddr = raddr_w[AW-1:0];

  function automatic logic better(input logic signed [KEY_W-1:0] a,
                                  input logic signed [KEY_W-1:0] b,
                                  input logic as_max);
    return as_max ? (a > b) : (a < b);
  endfunction

  function automatic logic odd_lvl(input logic [IW-1:0] i);
    logic [IW:0] v;
    logic r;
    v = {1'b0, i} + 1'b1;
    r = 1'b0;
    for (int b = 0; b <= IW; b++) begin
      if (v[b]) r = b[0];
    end
    return r;
  endfunction

  // candidate address for read step r: 0 is node, 1 is c1, then c2, grandchildren
  function automatic logic [IW-1:0] cand(input logic [IW-1:0] i, input logic [2:0] r);
    logic [IW-1:0] c;
    if (r == 3'd0) c = i;
    else if (r <= 3'd2) c = (i << 1) + IW'(r);
    else c = (i << 2) + IW'(r);
    return c;
  endfunction

  logic [IW-1:0] cur_c;
  assign cur_c = cand(pi, rcnt);

  always_comb begin
    raddr_w = '0;
    unique case (state)
      S_MINRD: raddr_w = (rcnt == 3'd3) ? IW'(n - 1'b1) : IW'(rcnt);
      S_CRD:   raddr_w = cur_c;
      S_PRD:   raddr_w = (m - 1'b1) >> 1;
      S_RPT:   raddr_w = IW'(rcnt);
      default: raddr_w = '0;
    endcase
  end

  // write port
  always_comb begin
    we = 1'b0;
    waddr = '0;
    wkey = kin;
    wact = ain;
    unique case (state)
      S_IDLE: begin
        if (start && !busy && opcode == OP_APPEND && n < NW'(CAPACITY)) begin
          we = 1'b1;
          waddr = n[AW-1:0];
          wkey = key;
          wact = action;
        end
      end
      S_OPDO: begin
        if (op == OP_SETMIN) begin
          we = 1'b1;
          waddr = minix;
          wkey = kin;
          wact = mact;
        end else if (op == OP_REMOVE) begin
          // widx 0: last entry into min slot, 1: min entry into last slot
          we = 1'b1;
          waddr = (widx == 3'd0) ? minix : AW'(n - 1'b1);
          wkey = (widx == 3'd0) ? pkey : mkey;
          wact = (widx == 3'd0) ? pact : mact;
        end else if (op == OP_REPLACE) begin
          we = 1'b1;
          waddr = '0;
          wkey = kin;
          wact = iact;
        end
      end
      S_SWP: begin
        we = 1'b1;
        waddr = (widx == 3'd0) ? pi[AW-1:0] : m[AW-1:0];
        wkey = (widx == 3'd0) ? mkey : ikey;
        wact = (widx == 3'd0) ? mact : iact;
      end
      S_PSWP: begin
        we = 1'b1;
        waddr = (widx == 3'd0) ? m[AW-1:0] : AW'((m - 1'b1) >> 1);
        wkey = (widx == 3'd0) ? pkey : ikey;
        wact = (widx == 3'd0) ? pact : iact;
      end
      default: we = 1'b0;
    endcase
  end

  logic [IW-1:0] rd_addr_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      n <= '0;
      done <= 1'b0;
      rcnt <= '0;
      widx <= '0;
    end else begin
      done <= (state == S_DONE);
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op <= opcode;
            kin <= key;
            ain <= action;
            err <= 1'b0;
            rcnt <= '0;
            widx <= '0;
            unique case (opcode)
              OP_APPEND: begin
                if (n < NW'(CAPACITY)) n <= n + 1'b1;
                else err <= 1'b1;
                state <= S_RPT;
              end
              OP_BUILD: begin
                bnode <= n >> 1;
                pn <= n;
                state <= S_PDSET;
              end
              OP_REPLACE, OP_SETMIN, OP_REMOVE: begin
                if (n == '0) begin
                  err <= 1'b1;
                  state <= S_RPT;
                end else begin
                  state <= S_MINRD;
                end
              end
              default: state <= S_RPT;
            endcase
          end
        end
        // reads: 0, 1, 2, last
        S_MINRD: begin
          rcnt <= rcnt;
          state <= S_MINWT;
        end
        S_MINWT: begin
          if (rcnt == 3'd0) begin
            ikey <= rkey;
            iact <= ract;
          end else if (rcnt == 3'd1) begin
            k1 <= rkey;
            mkey <= rkey;
            mact <= ract;
          end else if (rcnt == 3'd2) begin
            // min index per count, ties go to index 2
            if (n <= NW'(1)) begin
              minix <= '0;
              mkey <= ikey;
              mact <= iact;
            end else if (n == NW'(2) || k1 < rkey) begin
              minix <= AW'(1);
            end else begin
              minix <= AW'(2);
              mkey <= rkey;
              mact <= ract;
            end
          end else begin
            pkey <= rkey;
            pact <= ract;
          end
          if (rcnt == 3'd3) begin
            widx <= '0;
            state <= S_OPDO;
          end else begin
            rcnt <= rcnt + 1'b1;
            state <= S_MINRD;
          end
        end
        S_OPDO: begin
          unique case (op)
            OP_REMOVE: begin
              widx <= widx + 1'b1;
              if (widx == 3'd1) begin
                n <= n - 1'b1;
                if (n > NW'(3)) begin
                  pi <= IW'(minix);
                  pn <= n - 1'b1;
                  pmax <= 1'b0;
                  bnode <= '0;
                  rcnt <= '0;
                  state <= S_CRD;
                end else begin
                  rcnt <= '0;
                  state <= S_RPT;
                end
              end
            end
            OP_REPLACE: begin
              pi <= '0;
              pn <= n;
              pmax <= 1'b1;
              bnode <= '0;
              rcnt <= '0;
              state <= S_CRD;
            end
            default: begin
              rcnt <= '0;
              state <= S_RPT;
            end
          endcase
        end
        S_PDSET: begin
          rcnt <= '0;
          if (bnode == '0) begin
            state <= S_RPT;
          end else begin
            pi <= IW'(bnode - 1'b1);
            pmax <= !odd_lvl(IW'(bnode - 1'b1));
            bnode <= bnode - 1'b1;
            state <= S_CRD;
          end
        end
        S_CRD: begin
          if (pi >= IW'(pn >> 1)) begin
            state <= (op == OP_BUILD) ? S_PDSET : S_RPT;
            rcnt <= '0;
          end else if (rcnt != 3'd0 && cur_c >= IW'(pn)) begin
            // candidate list ends; decide
            rcnt <= '0;
            widx <= '0;
            if (m <= (pi << 1) + 2'd2) begin
              if (better(mkey, ikey, pmax)) state <= S_SWP;
              else state <= (op == OP_BUILD) ? S_PDSET : S_RPT;
            end else begin
              if (better(mkey, ikey, pmax)) state <= S_SWP;
              else state <= (op == OP_BUILD) ? S_PDSET : S_RPT;
            end
          end else begin
            rd_addr_q <= cur_c;
            state <= S_CWT;
          end
        end
        S_CWT: begin
          if (rcnt == 3'd0) begin
            ikey <= rkey;
            iact <= ract;
          end else if (rcnt == 3'd1 || better(rkey, mkey, pmax)) begin
            mkey <= rkey;
            mact <= ract;
            m <= rd_addr_q;
          end
          if (rcnt == 3'd6) begin
            rcnt <= '0;
            widx <= '0;
            if (better(better(rkey, mkey, pmax) ? rkey : mkey, ikey, pmax)) begin
              state <= S_SWP;
            end else begin
              state <= (op == OP_BUILD) ? S_PDSET : S_RPT;
            end
          end else begin
            rcnt <= rcnt + 1'b1;
            state <= S_CRD;
          end
        end
        S_SWP: begin
          if (widx == 3'd1) begin
            widx <= '0;
            if (m <= (pi << 1) + 2'd2) begin
              state <= (op == OP_BUILD) ? S_PDSET : S_RPT;
              rcnt <= '0;
            end else begin
              state <= S_PRD;
            end
          end else begin
            widx <= widx + 1'b1;
          end
        end
        S_PRD: state <= S_PWT;
        S_PWT: begin
          pkey <= rkey;
          pact <= ract;
          // entry now at m is the old node (ikey)
          if (better(rkey, ikey, pmax)) begin
            widx <= '0;
            state <= S_PSWP;
          end else begin
            pi <= m;
            rcnt <= '0;
            state <= S_CRD;
          end
        end
        S_PSWP: begin
          widx <= widx + 1'b1;
          if (widx == 3'd1) begin
            pi <= m;
            rcnt <= '0;
            state <= S_CRD;
          end
        end
        S_RPT: state <= S_RWT;
        S_RWT: begin
          rep_key[rcnt[1:0]] <= rkey;
          rep_act[rcnt[1:0]] <= ract;
          if (rcnt == 3'd2) state <= S_DONE;
          else begin
            rcnt <= rcnt + 1'b1;
            state <= S_RPT;
          end
        end
        S_DONE: begin
          state <= S_IDLE;
          if (n == '0) begin
            max_key <= '0; max_action <= '0; min_key <= '0; min_act <= '0;
          end else begin
            max_key <= rep_key[0];
            max_action <= rep_act[0];
            if (n == NW'(1)) begin
              min_key <= rep_key[0]; min_act <= rep_act[0];
            end else if (n == NW'(2) || rep_key[1] < rep_key[2]) begin
              min_key <= rep_key[1]; min_act <= rep_act[1];
            end else begin
              min_key <= rep_key[2]; min_act <= rep_act[2];
            end
          end
          count <= CNT_W'(n);
          is_empty <= (n == '0);
          op_error <= err;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held longer than a cycle");
  a_cnt_range: assert property (@(posedge clk) disable iff (rst) n <= NW'(CAPACITY))
    else $error("entry count beyond capacity");
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");
  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    done |-> (is_empty == (count == '0)))
    else $error("empty flag disagrees with count");
`endif
endmodule
